@@ rtl/tmq_pkg.sv @@
// shared constants, types and codes for the timer expiry queue
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps

package tmq_pkg;

  localparam int SLOTS     = 16;
  localparam int TIME_BITS = 48;
  localparam int TAG_BITS  = 8;
  localparam int SLOT_W    = $clog2(SLOTS);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [SLOT_W:0]      cnt_t;

  localparam time_t TIME_MAX = {TIME_BITS{1'b1}};

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ADD_ACK    = 2'd0;
  localparam logic [1:0] KIND_CANCEL_ACK = 2'd1;
  localparam logic [1:0] KIND_EXPIRED    = 2'd2;
  localparam logic [1:0] KIND_TICK_DONE  = 2'd3;

  typedef enum logic [1:0] {
    ALU_LT  = 2'd0,
    ALU_LE  = 2'd1,
    ALU_ADD = 2'd2
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    time_t   a;
    time_t   b;
  } alu_req_t;

  typedef struct packed {
    logic  flag;
    time_t sum;
  } alu_rsp_t;

  // write side of the slot file
  typedef struct packed {
    logic  ins;
    logic  dl_we;
    logic  clr;
    slot_t addr;
    time_t dl;
    time_t per;
    tag_t  tag;
  } slot_wr_t;

  typedef struct packed {
    time_t dl;
    time_t per;
    tag_t  tag;
  } slot_rd_t;

endpackage

@@ rtl/timer_expiry_queue.sv @@
// timer table; expiries leave in deadline order. one request at a time, busy while
// it runs. add: min scan, then insert unless full; cancel: check, then min scan;
// tick: time step, due scan, selection scans, re-arm, min scan; all via the single
// compare/add unit. results come one per cycle from the result register; the
// receiver cannot stall. sync reset clears time, tag counter, valid bits, sequencer.
`timescale 1ns / 1ps

module timer_expiry_queue import tmq_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     req_type,
  input  time_t          expire_at,
  input  time_t          period,
  input  slot_t          cancel_slot,
  input  tag_t           cancel_tag,
  output logic           result_strobe,
  output logic [1:0]     kind,
  output logic           status,
  output slot_t          slot,
  output tag_t           tag,
  output time_t          next_deadline,
  output logic           next_valid,
  output logic           earliest_changed,
  output logic           last
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CANCEL = 9'b000000010,
    S_TICK   = 9'b000000100,
    S_DUE    = 9'b000001000,
    S_SEL    = 9'b000010000,
    S_PICK   = 9'b000100000,
    S_REARM  = 9'b001000000,
    S_MIN    = 9'b010000000,
    S_INSERT = 9'b100000000
  } state_t;

  // emit is folded into a flag so the enum stays a pure sequencer
  state_t           state;
  logic             emitting;

  logic [1:0]       req;
  time_t            when_r;
  time_t            per_r;
  slot_t            cs_r;
  tag_t             ct_r;
  time_t            now;
  tag_t             tag_ctr;
  tag_t             ins_tag;
  slot_t            idx;
  slot_t            free_slot;
  logic             full;
  logic             cstat;
  logic             changed;
  time_t            min_val;
  logic             min_any;
  time_t            best_val;
  slot_t            best_slot;
  logic             best_any;
  logic [SLOTS-1:0] due;
  slot_t            order [SLOTS];
  cnt_t             n;
  cnt_t             k;

  slot_t            rd_addr;
  slot_rd_t         rd;
  logic [SLOTS-1:0] valid;
  slot_wr_t         wr;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  slot_t            free_enc;
  logic             idx_last;
  logic             cancel_hit;
  slot_t            emit_slot;

  tmq_slot_file u_slots (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd      (rd),
    .valid   (valid)
  );

  tmq_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign busy     = (state != S_IDLE) || emitting;
  assign idx_last = (idx == SLOT_W'(SLOTS - 1));
  assign emit_slot = order[k[SLOT_W-1:0]];
  assign cancel_hit = (32'(cs_r) < SLOTS) && valid[cs_r] && (rd.tag == ct_r);

  // lowest free slot
  always_comb begin
    free_enc = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) free_enc = SLOT_W'(i);
    end
  end

  // read address, shared unit operands and slot writes
  always_comb begin
    rd_addr     = idx;
    alu_req.op  = ALU_LT;
    alu_req.a   = rd.dl;
    alu_req.b   = min_val;
    wr.ins      = 1'b0;
    wr.dl_we    = 1'b0;
    wr.clr      = 1'b0;
    wr.addr     = idx;
    wr.dl       = alu_rsp.sum;
    wr.per      = per_r;
    wr.tag      = tag_ctr;
    if (emitting) begin
      rd_addr = emit_slot;
    end else begin
      unique case (state)
        S_CANCEL: begin
          rd_addr = cs_r;
          wr.addr = cs_r;
          wr.clr  = cancel_hit;
        end
        S_TICK: begin
          alu_req.op = ALU_ADD;
          alu_req.a  = now;
          alu_req.b  = time_t'(1);
        end
        S_DUE: begin
          alu_req.op = ALU_LE;
          alu_req.b  = now;
        end
        S_SEL: begin
          alu_req.b = best_val;
        end
        S_REARM: begin
          rd_addr    = emit_slot;
          wr.addr    = emit_slot;
          alu_req.op = ALU_ADD;
          alu_req.a  = now;
          alu_req.b  = rd.per;
          wr.dl_we   = (rd.per != '0);
          wr.clr     = (rd.per == '0);
        end
        S_INSERT: begin
          alu_req.a = when_r;
          wr.addr   = free_slot;
          wr.dl     = when_r;
          wr.ins    = 1'b1;
        end
        default: begin
          rd_addr = idx;
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      emitting <= 1'b0;
      now      <= '0;
      tag_ctr  <= '0;
      n        <= '0;
      k        <= '0;
    end else if (emitting) begin
      if (req == REQ_TICK && k != n) begin
        k <= k + cnt_t'(1);
      end else begin
        emitting <= 1'b0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req       <= req_type;
            when_r    <= expire_at;
            per_r     <= period;
            cs_r      <= cancel_slot;
            ct_r      <= cancel_tag;
            free_slot <= free_enc;
            full      <= &valid;
            idx       <= '0;
            min_any   <= 1'b0;
            changed   <= 1'b0;
            unique case (req_type)
              REQ_ADD:    state <= S_MIN;
              REQ_CANCEL: state <= S_CANCEL;
              REQ_TICK:   state <= S_TICK;
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_CANCEL: begin
          cstat <= !cancel_hit;
          state <= S_MIN;
        end
        S_TICK: begin
          now   <= alu_rsp.sum;
          due   <= '0;
          n     <= '0;
          k     <= '0;
          state <= S_DUE;
        end
        S_DUE: begin
          due[idx] <= valid[idx] & alu_rsp.flag;
          idx      <= idx + SLOT_W'(1);
          if (idx_last) begin
            best_any <= 1'b0;
            state    <= S_SEL;
          end
        end
        S_SEL: begin
          if (due[idx] && (!best_any || alu_rsp.flag)) begin
            best_val  <= rd.dl;
            best_slot <= idx;
            best_any  <= 1'b1;
          end
          idx <= idx + SLOT_W'(1);
          if (idx_last) state <= S_PICK;
        end
        S_PICK: begin
          k <= '0;
          if (best_any) begin
            order[n[SLOT_W-1:0]] <= best_slot;
            due[best_slot]       <= 1'b0;
            n                    <= n + cnt_t'(1);
            best_any             <= 1'b0;
            state                <= S_SEL;
          end else if (n == '0) begin
            state <= S_MIN;
          end else begin
            state <= S_REARM;
          end
        end
        S_REARM: begin
          if (k == n - cnt_t'(1)) begin
            k     <= '0;
            state <= S_MIN;
          end else begin
            k <= k + cnt_t'(1);
          end
        end
        S_MIN: begin
          if (valid[idx] && (!min_any || alu_rsp.flag)) begin
            min_val <= rd.dl;
            min_any <= 1'b1;
          end
          idx <= idx + SLOT_W'(1);
          if (idx_last) begin
            if (req == REQ_ADD && !full) begin
              state <= S_INSERT;
            end else begin
              state    <= S_IDLE;
              emitting <= 1'b1;
            end
          end
        end
        S_INSERT: begin
          changed <= !min_any || alu_rsp.flag;
          if (!min_any || alu_rsp.flag) min_val <= when_r;
          min_any  <= 1'b1;
          ins_tag  <= tag_ctr;
          tag_ctr  <= tag_ctr + tag_t'(1);
          state    <= S_IDLE;
          emitting <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register, one beat per cycle while emitting
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emitting;
    end
  end

  always_ff @(posedge clk) begin
    if (emitting) begin
      next_deadline <= min_any ? min_val : '0;
      next_valid    <= min_any;
      case (req)
        REQ_ADD: begin
          kind             <= KIND_ADD_ACK;
          status           <= full;
          earliest_changed <= changed & !full;
          slot             <= full ? '0 : free_slot;
          tag              <= full ? '0 : ins_tag;
          last             <= 1'b1;
        end
        REQ_CANCEL: begin
          kind             <= KIND_CANCEL_ACK;
          status           <= cstat;
          earliest_changed <= 1'b0;
          slot             <= cs_r;
          tag              <= ct_r;
          last             <= 1'b1;
        end
        default: begin
          status           <= 1'b0;
          earliest_changed <= 1'b0;
          if (k != n) begin
            kind <= KIND_EXPIRED;
            slot <= emit_slot;
            tag  <= rd.tag;
            last <= 1'b0;
          end else begin
            kind <= KIND_TICK_DONE;
            slot <= '0;
            tag  <= '0;
            last <= 1'b1;
          end
        end
      endcase
    end
  end

  // an expired beat is always followed by another beat
  a_exp_followed: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |=> result_strobe)
    else $error("expired beat not followed by another result");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last |-> !busy)
    else $error("block still busy after final result");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req_type == REQ_ADD || req_type == REQ_CANCEL ||
    req_type == REQ_TICK) |=> busy)
    else $error("accepted request did not raise busy");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !next_valid |-> next_deadline == '0)
    else $error("next deadline nonzero with nothing pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(n) <= SLOTS && k <= n)
    else $error("expiry count out of range");

endmodule

@@ rtl/tmq_alu.sv @@
// shared compare / saturating add unit of the timer expiry queue
// one adder serves a < b, a <= b and saturating a + b; uses tmq_pkg
`timescale 1ns / 1ps

module tmq_alu import tmq_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  time_t                x;
  time_t                y;
  logic                 cin;
  logic [TIME_BITS:0]   total;

  always_comb begin
    x   = req.a;
    y   = req.b;
    cin = 1'b0;
    unique case (req.op)
      ALU_LT: begin
        y   = ~req.b;
        cin = 1'b1;
      end
      ALU_LE: begin
        // b >= a, operands swapped
        x   = req.b;
        y   = ~req.a;
        cin = 1'b1;
      end
      ALU_ADD: begin
        cin = 1'b0;
      end
      default: begin
        cin = 1'b0;
      end
    endcase
    total = {1'b0, x} + {1'b0, y} + {{TIME_BITS{1'b0}}, cin};
    rsp.flag = (req.op == ALU_LT) ? ~total[TIME_BITS] : total[TIME_BITS];
    rsp.sum  = total[TIME_BITS] ? TIME_MAX : total[TIME_BITS-1:0];
  end

endmodule

@@ rtl/tmq_slot_file.sv @@
// per-slot timer storage: deadline, period, tag and valid bits
// one read address, one write address per cycle; uses tmq_pkg
`timescale 1ns / 1ps

module tmq_slot_file import tmq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  slot_t            rd_addr,
  input  slot_wr_t         wr,
  output slot_rd_t         rd,
  output logic [SLOTS-1:0] valid
);

  time_t dl  [SLOTS];
  time_t per [SLOTS];
  tag_t  tg  [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.ins) begin
      dl[wr.addr]  <= wr.dl;
      per[wr.addr] <= wr.per;
      tg[wr.addr]  <= wr.tag;
    end else if (wr.dl_we) begin
      dl[wr.addr] <= wr.dl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.ins) begin
      valid[wr.addr] <= 1'b1;
    end else if (wr.clr) begin
      valid[wr.addr] <= 1'b0;
    end
  end

  assign rd.dl  = dl[rd_addr];
  assign rd.per = per[rd_addr];
  assign rd.tag = tg[rd_addr];

endmodule

@@ tb/tmq_expiry_checker.sv @@
// checker for the timer expiry queue: predicts every result beat and compares it
// with what the block emits; depends on tmq_pkg for widths, codes and types
`timescale 1ns / 1ps

module tmq_expiry_checker import tmq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] req_type,
  input  time_t      expire_at,
  input  time_t      period,
  input  slot_t      cancel_slot,
  input  tag_t       cancel_tag,
  input  logic       result_strobe,
  input  logic [1:0] kind,
  input  logic       status,
  input  slot_t      slot,
  input  tag_t       tag,
  input  time_t      next_deadline,
  input  logic       next_valid,
  input  logic       earliest_changed,
  input  logic       last,
  output int         mismatches,
  output int         pending,
  output int         beats_checked,
  output int         expiries_seen
);

  typedef struct packed {
    logic [1:0] kind;
    logic       status;
    slot_t      slot;
    tag_t       tag;
    time_t      next_deadline;
    logic       next_valid;
    logic       earliest_changed;
    logic       last;
  } result_beat_t;

  result_beat_t expected_beats[$];

  // shadow of the timer table
  time_t now_ticks = '0;
  tag_t  next_tag = '0;
  logic  armed[SLOTS];
  time_t deadline_of[SLOTS];
  time_t period_of[SLOTS];
  tag_t  tag_of[SLOTS];

  int fail_n = 0;
  int beat_n = 0;
  int expiry_n = 0;

  function automatic time_t sat_sum(time_t a, time_t b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
  endfunction

  function automatic logic earliest_deadline(output time_t m);
    logic any;
    any = 1'b0;
    m = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (armed[i] && (!any || deadline_of[i] < m)) begin
        m = deadline_of[i];
        any = 1'b1;
      end
    end
    return any;
  endfunction

  function automatic string describe(result_beat_t b);
    return $sformatf("kind %0d status %0d slot %0d tag %0d next %h valid %0d changed %0d last %0d",
                     b.kind, b.status, b.slot, b.tag, b.next_deadline, b.next_valid,
                     b.earliest_changed, b.last);
  endfunction

  task automatic predict_request(input logic [1:0] rq, input time_t ea, input time_t pe,
                                 input slot_t cs, input tag_t ct);
    int     free_slot;
    int     best;
    int     n;
    int     order[SLOTS];
    logic   due[SLOTS];
    logic   had;
    logic   changed;
    logic   nv;
    logic   st;
    time_t  old_min;
    time_t  nd;
    free_slot = -1;
    n = 0;
    case (rq)
      REQ_ADD: begin
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!armed[i]) free_slot = i;
        if (free_slot < 0) begin
          nv = earliest_deadline(nd);
          expected_beats.push_back({KIND_ADD_ACK, 1'b1, slot_t'(0), tag_t'(0), nd, nv,
                                    1'b0, 1'b1});
        end else begin
          had = earliest_deadline(old_min);
          changed = !had || ea < old_min;
          armed[free_slot] = 1'b1;
          deadline_of[free_slot] = ea;
          period_of[free_slot] = pe;
          tag_of[free_slot] = next_tag;
          next_tag = next_tag + 1'b1;
          nv = earliest_deadline(nd);
          expected_beats.push_back({KIND_ADD_ACK, 1'b0, slot_t'(free_slot),
                                    tag_of[free_slot], nd, nv, changed, 1'b1});
        end
      end
      REQ_CANCEL: begin
        st = 1'b1;
        if (armed[cs] && tag_of[cs] == ct) begin
          armed[cs] = 1'b0;
          st = 1'b0;
        end
        nv = earliest_deadline(nd);
        expected_beats.push_back({KIND_CANCEL_ACK, st, cs, ct, nd, nv, 1'b0, 1'b1});
      end
      REQ_TICK: begin
        now_ticks = sat_sum(now_ticks, time_t'(1));
        for (int i = 0; i < SLOTS; i++)
          due[i] = armed[i] && deadline_of[i] <= now_ticks;
        // deadline order, lower slot wins a tie
        for (int k = 0; k < SLOTS; k++) begin
          best = -1;
          for (int i = 0; i < SLOTS; i++)
            if (due[i] && (best < 0 || deadline_of[i] < deadline_of[best]))
              best = i;
          if (best >= 0) begin
            due[best] = 1'b0;
            order[n] = best;
            n++;
          end
        end
        for (int k = 0; k < n; k++) begin
          if (period_of[order[k]] != '0)
            deadline_of[order[k]] = sat_sum(now_ticks, period_of[order[k]]);
          else
            armed[order[k]] = 1'b0;
        end
        nv = earliest_deadline(nd);
        for (int k = 0; k < n; k++)
          expected_beats.push_back({KIND_EXPIRED, 1'b0, slot_t'(order[k]), tag_of[order[k]],
                                    nd, nv, 1'b0, 1'b0});
        expected_beats.push_back({KIND_TICK_DONE, 1'b0, slot_t'(0), tag_t'(0), nd, nv,
                                  1'b0, 1'b1});
      end
      default: ;  // unknown request: no result
    endcase
  endtask

  task automatic check_beat();
    result_beat_t got;
    result_beat_t want;
    got = {kind, status, slot, tag, next_deadline, next_valid, earliest_changed, last};
    if (expected_beats.size() == 0) begin
      fail_n++;
      if (fail_n <= 10)
        $display("unexpected result beat: %s", describe(got));
    end else begin
      want = expected_beats.pop_front();
      beat_n++;
      if (want.kind == KIND_EXPIRED)
        expiry_n++;
      if (got !== want) begin
        fail_n++;
        if (fail_n <= 10) begin
          $display("mismatch on beat %0d, expected %s", beat_n, describe(want));
          $display("                     actual   %s", describe(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      now_ticks = '0;
      next_tag = '0;
      for (int i = 0; i < SLOTS; i++) begin
        armed[i] = 1'b0;
        deadline_of[i] = '0;
        period_of[i] = '0;
        tag_of[i] = '0;
      end
      expected_beats.delete();
    end else begin
      // old beats before new predictions, the queue is in order anyway
      if (result_strobe)
        check_beat();
      if (start && !busy)
        predict_request(req_type, expire_at, period, cancel_slot, cancel_tag);
    end
    mismatches <= fail_n;
    pending <= expected_beats.size();
    beats_checked <= beat_n;
    expiries_seen <= expiry_n;
  end

endmodule

@@ tb/timer_expiry_queue_test.sv @@
// top of the timer expiry queue testbench: clock, reset, directed and random requests
// depends on tmq_pkg, the timer_expiry_queue block and tmq_expiry_checker
`timescale 1ns / 1ps

module timer_expiry_queue_test import tmq_pkg::*; ();

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int RANDOM_ITEMS = 83;
  localparam int QUIET_TAIL   = 20;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 400;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] req_type;
  time_t      expire_at;
  time_t      period;
  slot_t      cancel_slot;
  tag_t       cancel_tag;
  logic       result_strobe;
  logic [1:0] kind;
  logic       status;
  slot_t      slot;
  tag_t       tag;
  time_t      next_deadline;
  logic       next_valid;
  logic       earliest_changed;
  logic       last;

  int mismatches;
  int pending;
  int beats_checked;
  int expiries_seen;

  typedef struct packed {
    slot_t s;
    tag_t  t;
  } timer_handle_t;

  timer_handle_t live_handles[$];
  longint ticks_sent = 0;
  int     items_sent = 0;
  int     cycles = 0;

  timer_expiry_queue uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .expire_at(expire_at), .period(period),
    .cancel_slot(cancel_slot), .cancel_tag(cancel_tag),
    .result_strobe(result_strobe), .kind(kind), .status(status), .slot(slot), .tag(tag),
    .next_deadline(next_deadline), .next_valid(next_valid),
    .earliest_changed(earliest_changed), .last(last)
  );

  tmq_expiry_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .expire_at(expire_at), .period(period),
    .cancel_slot(cancel_slot), .cancel_tag(cancel_tag),
    .result_strobe(result_strobe), .kind(kind), .status(status), .slot(slot), .tag(tag),
    .next_deadline(next_deadline), .next_valid(next_valid),
    .earliest_changed(earliest_changed), .last(last),
    .mismatches(mismatches), .pending(pending),
    .beats_checked(beats_checked), .expiries_seen(expiries_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // remember handed-out timers so cancels can hit live ones; sampled mid-cycle
  always @(negedge clk) begin
    if (!rst && result_strobe && kind == KIND_ADD_ACK && !status) begin
      live_handles.push_back({slot, tag});
      if (live_handles.size() > 16)
        void'(live_handles.pop_front());
    end
  end

  function automatic time_t rand_time();
    return time_t'({$urandom, $urandom});
  endfunction

  // idle bursts in alternating stretches, none near the end
  function automatic int pick_gap(int k, int total);
    if (k >= total - QUIET_TAIL || ((k / 12) % 2) != 0)
      return 0;
    return ($urandom_range(0, 1) != 0) ? int'($urandom_range(1, 8)) : 0;
  endfunction

  // start stays high from one beat to the next unless a gap comes in between
  task automatic issue(input int gap, input logic [1:0] rq, input time_t ea, input time_t pe,
                       input slot_t cs, input tag_t ct);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= rq;
    expire_at <= ea;
    period <= pe;
    cancel_slot <= cs;
    cancel_tag <= ct;
    do @(posedge clk); while (busy);
    items_sent++;
    if (rq == REQ_TICK)
      ticks_sent++;
  endtask

  initial begin
    int            r;
    int            idx;
    time_t         ea;
    time_t         pe;
    timer_handle_t h;
    rst = 1'b1;
    start = 1'b0;
    req_type = REQ_ADD;
    expire_at = '0;
    period = '0;
    cancel_slot = '0;
    cancel_tag = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, odd request, past deadline, saturating re-arm, ties
    issue(0, REQ_CANCEL, rand_time(), rand_time(), slot_t'(0), tag_t'(0));
    issue(2, REQ_TICK, '0, '0, slot_t'(0), tag_t'(0));
    issue(0, REQ_UNKNOWN, TIME_MAX, TIME_MAX, slot_t'(15), tag_t'(8'hFF));
    issue(0, REQ_ADD, '0, TIME_MAX, slot_t'(0), tag_t'(0));
    issue(1, REQ_ADD, TIME_MAX, '0, slot_t'(0), tag_t'(0));
    issue(0, REQ_ADD, time_t'(ticks_sent + 2), time_t'(1), slot_t'(0), tag_t'(0));
    issue(0, REQ_ADD, '0, '0, slot_t'(0), tag_t'(0));
    issue(0, REQ_TICK, '0, '0, slot_t'(0), tag_t'(0));
    issue(3, REQ_TICK, '0, '0, slot_t'(0), tag_t'(0));
    issue(0, REQ_CANCEL, '0, '0, slot_t'(1), tag_t'(1));
    issue(0, REQ_CANCEL, '0, '0, slot_t'(2), tag_t'(8'hFF));
    // fill the table with timers due on the next tick, then overflow it
    for (int i = 0; i < 14; i++)
      issue(pick_gap(i, 100), REQ_ADD, time_t'(ticks_sent + 1), '0, slot_t'(0), tag_t'(0));
    issue(0, REQ_ADD, time_t'(ticks_sent + 1), '0, slot_t'(0), tag_t'(0));
    issue(0, REQ_TICK, '0, '0, slot_t'(0), tag_t'(0));

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      r = $urandom_range(0, 99);
      if (r < 42) begin
        issue(pick_gap(k, RANDOM_ITEMS), REQ_TICK, rand_time(), rand_time(),
              slot_t'($urandom_range(0, 15)), tag_t'($urandom_range(0, 255)));
      end else if (r < 78) begin
        r = $urandom_range(0, 9);
        if (r <= 6)
          ea = time_t'(ticks_sent + $urandom_range(0, 6));
        else if (r == 7)
          ea = (ticks_sent > 3) ? time_t'(ticks_sent - $urandom_range(1, 3)) : '0;
        else if (r == 8)
          ea = rand_time();
        else
          ea = time_t'(ticks_sent + $urandom_range(7, 40));
        r = $urandom_range(0, 19);
        if (r < 11)
          pe = '0;
        else if (r < 18)
          pe = time_t'($urandom_range(1, 5));
        else if (r == 18)
          pe = rand_time();
        else
          pe = time_t'($urandom_range(6, 30));
        issue(pick_gap(k, RANDOM_ITEMS), REQ_ADD, ea, pe,
              slot_t'($urandom_range(0, 15)), tag_t'($urandom_range(0, 255)));
      end else if (r < 96) begin
        if (live_handles.size() > 0 && $urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, live_handles.size() - 1);
          h = live_handles[idx];
          live_handles.delete(idx);
        end else begin
          h = {slot_t'($urandom_range(0, 15)), tag_t'($urandom_range(0, 255))};
        end
        issue(pick_gap(k, RANDOM_ITEMS), REQ_CANCEL, rand_time(), rand_time(), h.s, h.t);
      end else begin
        issue(pick_gap(k, RANDOM_ITEMS), REQ_UNKNOWN, rand_time(), rand_time(),
              slot_t'($urandom_range(0, 15)), tag_t'($urandom_range(0, 255)));
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d of them ticks; %0d result beats checked, %0d expiries",
             items_sent, ticks_sent, beats_checked, expiries_seen);
    $display("%0d mismatches, %0d beats left unmatched", mismatches, pending);
    if (mismatches == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
